[rtl/jls_pkg.sv]
package jls_pkg;

  localparam int MAX_COLS   = 4096;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int CNT_W      = COL_W + 1;
  localparam int ROW_W      = 16;
  localparam int CC_W       = 13;
  localparam int CMP_W      = (CC_W > CNT_W) ? CC_W : CNT_W;
  localparam int MIN_DIM    = 3;
  localparam int VAL_W      = 32;
  localparam int CHG_W      = 31;
  localparam int SUM_W      = VAL_W + 2;
  localparam int Q_DEPTH    = 8;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = Q_PTR_W + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT = 1'b0,
    CFG_COL_COUNT = 1'b1
  } jls_cfg_idx_t;

  typedef struct packed {
    logic has_out;
    logic interior;
    logic last_row;
    logic last_col;
  } jls_flags_t;

  typedef struct packed {
    logic [VAL_W-1:0] new_value;
    logic [VAL_W-1:0] border_value;
    logic [CHG_W-1:0] max_change;
    logic             two;
    logic             sweep_end;
  } jls_entry_t;

endpackage

[rtl/jls_row_window.sv]
module jls_row_window (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [jls_pkg::COL_W-1:0] rd_col,
  input  logic [jls_pkg::VAL_W-1:0] wr_value,
  input  logic                      up_wr_en,
  input  logic [jls_pkg::COL_W-1:0] up_wr_col,
  output logic [jls_pkg::VAL_W-1:0] centre,
  output logic [jls_pkg::VAL_W-1:0] next_right,
  output logic [jls_pkg::VAL_W-1:0] upper
);
  import jls_pkg::*;

  logic [VAL_W-1:0] mid_mem [MAX_COLS];
  logic [VAL_W-1:0] up_mem  [MAX_COLS];
  logic [VAL_W-1:0] mid_rd0_r;
  logic [VAL_W-1:0] mid_rd1_r;
  logic [VAL_W-1:0] up_rd_r;
  logic [COL_W-1:0] right_col;

  // wraps at the top column, where the value is never used
  assign right_col = rd_col + COL_W'(1);

  // middle row: read centre and right neighbour, replace centre with incoming word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mid_rd0_r        <= mid_mem[rd_col];
      mid_rd1_r        <= mid_mem[right_col];
      mid_mem[rd_col]  <= wr_value;
    end
  end

  // upper row takes the old centre in the cycle after it is read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      up_rd_r <= up_mem[rd_col];
    end
    if (up_wr_en) begin
      up_mem[up_wr_col] <= mid_rd0_r;
    end
  end

  assign centre     = mid_rd0_r;
  assign next_right = mid_rd1_r;
  assign upper      = up_rd_r;

endmodule

[rtl/jls_out_queue.sv]
module jls_out_queue (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  input  jls_pkg::jls_entry_t                push_entry,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic signed [jls_pkg::VAL_W-1:0]   out_new_value,
  output logic [jls_pkg::CHG_W-1:0]          out_max_change,
  output logic                               out_sweep_end,
  output logic                               out_run_end,
  output logic [jls_pkg::Q_CNT_W-1:0]        level
);
  import jls_pkg::*;

  jls_entry_t         mem [Q_DEPTH];
  jls_entry_t         head;
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] level_r, level_nxt;
  logic               half_r, half_nxt;
  logic               take;
  logic               done;

  assign head      = mem[rd_ptr_r];
  assign out_valid = (level_r != '0);
  assign take      = out_valid && !out_stall;
  // an entry of the last row carries two words: stencil cell, then border cell
  assign done      = take && (!head.two || half_r);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = done ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    level_nxt  = level_r + Q_CNT_W'(push) - Q_CNT_W'(done);
    half_nxt   = take ? !done : half_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
      half_r   <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
      half_r   <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  assign out_new_value  = half_r ? head.border_value : head.new_value;
  assign out_max_change = head.max_change;
  assign out_sweep_end  = half_r && head.sweep_end;
  assign out_run_end    = half_r || !head.two;
  assign level          = level_r;

endmodule

[rtl/jacobi_laplace_stencil_sweep_top.sv]
// one jacobi sweep over a grid streamed in row-major order, signed q8.24 words
//
// input channel in_valid/in_stall carries in_grid_value; output channel
// out_valid/out_stall carries new_value, max_change, sweep_end, run_end.
// a word moves at a clock edge with valid high and stall low.
// cfg_valid/cfg_ready writes row_count (index 0) or col_count (index 1);
// cfg_ready is always high. write only while the block is drained.
//
// results lag the input by one row: words of row zero give nothing, each later
// word gives the cell one row above it, and each word of the last row also
// gives itself as a border cell, so each word of the last row yields two results.
// one word per cycle is taken while in_stall is low; the row stores are read and
// rewritten once per word, the right neighbor from a second read port.
// a result passes the stage 1, 2 and 3 registers and the output queue before it shows.
//
// reset clears positions, the running maximum and the output queue; counts go
// to 3. row store contents stay undefined until written. when the receiver
// stalls, results collect in an 8-deep queue and in_stall rises once queue
// plus pipeline would fill it; no word is lost or repeated.
module jacobi_laplace_stencil_sweep_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [jls_pkg::VAL_W-1:0]     in_grid_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [jls_pkg::VAL_W-1:0]     out_new_value,
  output logic [jls_pkg::CHG_W-1:0]            out_max_change,
  output logic                                 out_sweep_end,
  output logic                                 out_run_end,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [jls_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [jls_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import jls_pkg::*;

  logic [ROW_W-1:0]     row_count_r;
  logic [CC_W-1:0]      col_count_r;
  logic [ROW_W-1:0]     row_pos_r, row_pos_nxt;
  logic [COL_W-1:0]     col_pos_r, col_pos_nxt;

  logic [ROW_W-1:0]     rows_eff;
  logic [CMP_W-1:0]     cc_ext;
  logic [CNT_W-1:0]     cols_eff;
  logic [ROW_W-1:0]     r_sel;
  logic [COL_W-1:0]     c_sel;
  jls_flags_t           f0;
  logic                 in_acc;

  logic                 v1_r, v2_r, v3_r;
  jls_flags_t           f1_r, f2_r, f3_r;
  logic [COL_W-1:0]     c1_r;
  logic [VAL_W-1:0]     x1_r, x2_r, x3_r;
  logic [VAL_W-1:0]     cen2_r, nv3_r;
  logic [SUM_W-1:0]     sum2_r, sum1;
  logic [CHG_W-1:0]     d3_r, d2;
  logic [VAL_W-1:0]     left_r;
  logic [CHG_W-1:0]     max_r, max_nxt, new_max;

  logic [VAL_W-1:0]     win_cen, win_right, win_up;
  logic [VAL_W-1:0]     nv2;
  logic [VAL_W:0]       diff2, abs2;

  jls_entry_t           entry;
  logic                 push;
  logic [Q_CNT_W-1:0]   level;
  logic [Q_CNT_W:0]     occ;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROW_W'(MIN_DIM);
      col_count_r <= CC_W'(MIN_DIM);
    end else if (cfg_valid) begin
      case (jls_cfg_idx_t'(cfg_index))
        CFG_ROW_COUNT: row_count_r <= cfg_data[ROW_W-1:0];
        CFG_COL_COUNT: col_count_r <= cfg_data[CC_W-1:0];
        default: ;
      endcase
    end
  end

  // position and window flags
  always_comb begin
    rows_eff = (row_count_r < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : row_count_r;
    cc_ext   = CMP_W'(col_count_r);
    if (cc_ext < CMP_W'(MIN_DIM)) begin
      cols_eff = CNT_W'(MIN_DIM);
    end else if (cc_ext > CMP_W'(MAX_COLS)) begin
      cols_eff = CNT_W'(MAX_COLS);
    end else begin
      cols_eff = CNT_W'(cc_ext);
    end
    // a count shrunk in mid-sweep pins the position to the last row or column
    r_sel = (row_pos_r >= rows_eff) ? rows_eff - ROW_W'(1) : row_pos_r;
    if (CNT_W'(col_pos_r) >= cols_eff) begin
      c_sel = COL_W'(cols_eff - CNT_W'(1));
    end else begin
      c_sel = col_pos_r;
    end
    f0.last_row = (r_sel == rows_eff - ROW_W'(1));
    f0.last_col = (CNT_W'(c_sel) == cols_eff - CNT_W'(1));
    f0.has_out  = (r_sel != '0);
    f0.interior = (r_sel >= ROW_W'(2)) && (c_sel != '0) && !f0.last_col;

    if (f0.last_col) begin
      col_pos_nxt = '0;
      row_pos_nxt = f0.last_row ? '0 : r_sel + ROW_W'(1);
    end else begin
      col_pos_nxt = c_sel + COL_W'(1);
      row_pos_nxt = r_sel;
    end
  end

  assign occ      = (Q_CNT_W + 1)'(level) + (Q_CNT_W + 1)'(v1_r)
                  + (Q_CNT_W + 1)'(v2_r) + (Q_CNT_W + 1)'(v3_r);
  assign in_stall = (occ >= (Q_CNT_W + 1)'(Q_DEPTH));
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r <= '0;
      col_pos_r <= '0;
    end else if (in_acc) begin
      row_pos_r <= row_pos_nxt;
      col_pos_r <= col_pos_nxt;
    end
  end

  jls_row_window u_window (
    .clk        (clk),
    .rd_en      (in_acc),
    .rd_col     (c_sel),
    .wr_value   (in_grid_value),
    .up_wr_en   (v1_r),
    .up_wr_col  (c1_r),
    .centre     (win_cen),
    .next_right (win_right),
    .upper      (win_up)
  );

  // stage 1: four-neighbor sum, left neighbor is the previous word's centre
  assign sum1 = {{2{win_up[VAL_W-1]}}, win_up} + {{2{x1_r[VAL_W-1]}}, x1_r}
              + {{2{left_r[VAL_W-1]}}, left_r} + {{2{win_right[VAL_W-1]}}, win_right};

  // stage 2: quarter (floor) on interior cells, else keep the centre; absolute change, saturate
  always_comb begin
    nv2   = f2_r.interior ? sum2_r[SUM_W-1:2] : cen2_r;
    diff2 = {nv2[VAL_W-1], nv2} - {cen2_r[VAL_W-1], cen2_r};
    abs2  = diff2[VAL_W] ? -diff2 : diff2;
    d2    = (abs2[VAL_W:CHG_W] != '0) ? {CHG_W{1'b1}} : abs2[CHG_W-1:0];
  end

  // stage 3: running maximum, cleared after the last cell of a sweep, then into the queue
  always_comb begin
    new_max = (d3_r > max_r) ? d3_r : max_r;
    max_nxt = max_r;
    if (v3_r) begin
      max_nxt = (f3_r.last_row && f3_r.last_col) ? '0 : new_max;
    end
    push               = v3_r && f3_r.has_out;
    entry.new_value    = nv3_r;
    entry.border_value = x3_r;
    entry.max_change   = new_max;
    entry.two          = f3_r.last_row;
    entry.sweep_end    = f3_r.last_row && f3_r.last_col;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      left_r <= '0;
      max_r  <= '0;
    end else begin
      v1_r  <= in_acc;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      max_r <= max_nxt;
      if (v1_r) begin
        left_r <= win_cen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      f1_r <= f0;
      c1_r <= c_sel;
      x1_r <= in_grid_value;
    end
    if (v1_r) begin
      f2_r   <= f1_r;
      x2_r   <= x1_r;
      cen2_r <= win_cen;
      sum2_r <= sum1;
    end
    if (v2_r) begin
      f3_r  <= f2_r;
      x3_r  <= x2_r;
      nv3_r <= nv2;
      d3_r  <= d2;
    end
  end

  jls_out_queue u_queue (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .push_entry     (entry),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_new_value  (out_new_value),
    .out_max_change (out_max_change),
    .out_sweep_end  (out_sweep_end),
    .out_run_end    (out_run_end),
    .level          (level)
  );

  // a taken word must always find room in the queue, in flight words included
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (occ < (Q_CNT_W + 1)'(Q_DEPTH)))
    else $error("word taken without queue room");

  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    level <= Q_CNT_W'(Q_DEPTH))
    else $error("output queue overflow");

  a_sweep_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_sweep_end) |-> out_run_end)
    else $error("sweep end on a word that is not the last of its run");

  a_max_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && f3_r.last_row && f3_r.last_col) |=> (max_r == '0))
    else $error("running maximum not cleared after sweep");

endmodule
